// ===== sv/hattok_pkg.sv =====
// Types, codes and helpers shared by the header attribute tokenizer.
package hattok_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_AEND  = 2'd2,
    KIND_EOS   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    MODE_SKIP  = 3'd0,
    MODE_NAME  = 3'd1,
    MODE_NAMEQ = 3'd2,
    MODE_QUOTE = 3'd3,
    MODE_ESC   = 3'd4,
    MODE_UNQ   = 3'd5,
    MODE_AFTER = 3'd6
  } mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       run_end;
  } out_beat_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } res_ent_t;

  typedef struct packed {
    logic [CntW-1:0]            cnt;
    res_ent_t [MaxResults-1:0]  ent;
  } res_grp_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == ChSpace) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

endpackage

// ===== sv/hattok_decode.sv =====
// Combinational decode of one byte into its result group and the next parse mode.
module hattok_decode
  import hattok_pkg::*;
(
  input  mode_e     mode_i,
  input  in_beat_t  beat_i,
  output res_grp_t  grp_o,
  output mode_e     mode_o
);

  logic [7:0]      b;
  logic            fin;
  logic            ws;
  logic            use_name;
  logic [CntW-1:0] cnt;
  res_ent_t [MaxResults-1:0] ent;
  mode_e           nxt;

  assign b   = beat_i.data_byte;
  assign fin = beat_i.final_byte;
  assign ws  = is_ws(beat_i.data_byte);

  always_comb begin
    cnt      = '0;
    ent      = '0;
    nxt      = mode_i;
    use_name = 1'b0;

    case (mode_i)
      MODE_NAME: begin
        use_name = 1'b1;
      end
      MODE_NAMEQ: begin
        if (ws || b == ChEq) begin
          ent[cnt[1:0]] = '{kind: KIND_NAME, data: ChEq};
          cnt = cnt + 1'b1;
          use_name = 1'b1;
        end else if (b == ChQuote) begin
          nxt = MODE_QUOTE;
          if (fin) begin
            ent[cnt[1:0]] = '{kind: KIND_AEND, data: 8'd0};
            cnt = cnt + 1'b1;
          end
        end else if (b == ChComma) begin
          ent[cnt[1:0]] = '{kind: KIND_AEND, data: 8'd0};
          cnt = cnt + 1'b1;
          nxt = MODE_SKIP;
        end else begin
          ent[cnt[1:0]] = '{kind: KIND_VALUE, data: b};
          cnt = cnt + 1'b1;
          nxt = MODE_UNQ;
          if (fin) begin
            ent[cnt[1:0]] = '{kind: KIND_AEND, data: 8'd0};
            cnt = cnt + 1'b1;
          end
        end
      end
      MODE_QUOTE: begin
        if (b == ChQuote) begin
          ent[cnt[1:0]] = '{kind: KIND_AEND, data: 8'd0};
          cnt = cnt + 1'b1;
          nxt = MODE_AFTER;
        end else if (b == ChBslash && !fin) begin
          nxt = MODE_ESC;
        end else begin
          ent[cnt[1:0]] = '{kind: KIND_VALUE, data: b};
          cnt = cnt + 1'b1;
          if (fin) begin
            ent[cnt[1:0]] = '{kind: KIND_AEND, data: 8'd0};
            cnt = cnt + 1'b1;
          end
        end
      end
      MODE_ESC: begin
        ent[cnt[1:0]] = '{kind: KIND_VALUE, data: b};
        cnt = cnt + 1'b1;
        nxt = MODE_QUOTE;
        if (fin) begin
          ent[cnt[1:0]] = '{kind: KIND_AEND, data: 8'd0};
          cnt = cnt + 1'b1;
        end
      end
      MODE_UNQ: begin
        if (ws || b == ChComma) begin
          ent[cnt[1:0]] = '{kind: KIND_AEND, data: 8'd0};
          cnt = cnt + 1'b1;
          nxt = MODE_SKIP;
        end else begin
          ent[cnt[1:0]] = '{kind: KIND_VALUE, data: b};
          cnt = cnt + 1'b1;
          if (fin) begin
            ent[cnt[1:0]] = '{kind: KIND_AEND, data: 8'd0};
            cnt = cnt + 1'b1;
          end
        end
      end
      MODE_AFTER: begin
        if (ws || b == ChComma) begin
          nxt = MODE_SKIP;
        end else begin
          use_name = 1'b1;
        end
      end
      default: begin
        if (ws) begin
          nxt = MODE_SKIP;
        end else begin
          use_name = 1'b1;
        end
      end
    endcase

    if (use_name) begin
      if (ws) begin
        ent[cnt[1:0]] = '{kind: KIND_AEND, data: 8'd0};
        cnt = cnt + 1'b1;
        nxt = MODE_SKIP;
      end else if (b == ChEq && !fin) begin
        nxt = MODE_NAMEQ;
      end else begin
        ent[cnt[1:0]] = '{kind: KIND_NAME, data: b};
        cnt = cnt + 1'b1;
        nxt = MODE_NAME;
        if (fin) begin
          ent[cnt[1:0]] = '{kind: KIND_AEND, data: 8'd0};
          cnt = cnt + 1'b1;
        end
      end
    end

    if (fin) begin
      ent[cnt[1:0]] = '{kind: KIND_EOS, data: 8'd0};
      cnt = cnt + 1'b1;
      nxt = MODE_SKIP;
    end
  end

  assign grp_o  = '{cnt: cnt, ent: ent};
  assign mode_o = nxt;

endmodule

// ===== sv/hattok_emit.sv =====
// Result register that holds one byte's result group and sends it out one beat at a time.
module hattok_emit
  import hattok_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_grp_t  grp_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  res_ent_t [MaxResults-1:0] ent_q, ent_d;
  logic [CntW-1:0]           rem_q, rem_d;
  logic                      take;

  assign take        = (rem_q != '0) && !out_stall_i;
  assign ready_o     = (rem_q == '0) || ((rem_q == CntW'(1)) && !out_stall_i);
  assign out_valid_o = (rem_q != '0);
  assign out_beat_o  = '{kind: ent_q[0].kind, out_byte: ent_q[0].data,
                         run_end: (rem_q == CntW'(1))};

  always_comb begin
    ent_d = ent_q;
    rem_d = rem_q;
    if (load_i && grp_i.cnt != '0) begin
      ent_d = grp_i.ent;
      rem_d = grp_i.cnt;
    end else if (take) begin
      ent_d = {res_ent_t'('0), ent_q[MaxResults-1:1]};
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ===== sv/header_attribute_tokenizer_unit.sv =====
// Top level of the header attribute tokenizer: input register, mode register, decode and emit.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i, in_stall_o | in_beat_i  (data_byte, final_byte)
//   out     | output    | out_valid_o, out_stall_i | out_beat_o (kind, out_byte, run_end)
//
// A byte is registered, decoded against the parse mode and moved into the result register;
// a byte with one result flows at one byte per cycle while the output does not stall.
// A byte with n results sends them out as n beats, at most four.
// Bytes with no result leave the input register without waiting on the output.
// Reset puts the parse mode between attributes and empties both registers.
// An output stall holds the current beat and backs up into in_stall_o.
module header_attribute_tokenizer_unit
  import hattok_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  in_beat_t in_beat_q;
  logic     in_vld_q;
  mode_e    mode_q, mode_d;
  res_grp_t grp;
  logic     emit_ready;
  logic     xfer;
  logic     accept;

  hattok_decode u_decode (
    .mode_i (mode_q),
    .beat_i (in_beat_q),
    .grp_o  (grp),
    .mode_o (mode_d)
  );

  assign xfer       = in_vld_q && ((grp.cnt == '0) || emit_ready);
  assign in_stall_o = in_vld_q && !xfer;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= MODE_SKIP;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (xfer) begin
        in_vld_q <= 1'b0;
      end
      if (xfer) begin
        mode_q <= mode_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_beat_q <= in_beat_i;
    end
  end

  hattok_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (xfer),
    .grp_i       (grp),
    .ready_o     (emit_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

// ===== sv/hattok_chk.sv =====
// Port-level checker for the header attribute tokenizer and its bind.
module hattok_chk
  import hattok_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_beat_t  in_beat_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  // A stalled input beat stays valid and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_beat_i))
    else $error("stalled input beat changed");

  // A stalled output beat stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled output beat changed");

  // Events carry a zero byte.
  a_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.kind == KIND_AEND || out_beat_o.kind == KIND_EOS)
      |-> out_beat_o.out_byte == 8'd0)
    else $error("event beat with nonzero byte");

  // End of stream is always the last result of its byte.
  a_eos_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.kind == KIND_EOS |-> out_beat_o.run_end)
    else $error("end of stream not last in run");

  // The output is empty right after reset.
  a_no_early_out: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind header_attribute_tokenizer_unit hattok_chk u_hattok_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

// ===== tb/header_attribute_tokenizer_unit_tb.sv =====
// Self-checking testbench for the header attribute tokenizer: directed and random byte streams.
module header_attribute_tokenizer_unit_tb;
  import hattok_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 8;

  localparam logic [7:0] EqChar     = 8'h3D;
  localparam logic [7:0] QuoteChar  = 8'h22;
  localparam logic [7:0] BslashChar = 8'h5C;
  localparam logic [7:0] CommaChar  = 8'h2C;
  localparam logic [7:0] SpaceChar  = 8'h20;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  mode_e       tok_mode = MODE_SKIP;
  out_beat_t   step_tokens[$];
  out_beat_t   expected_tokens[$];
  int unsigned send_gap_max = 7;
  int unsigned recv_gap_max = 7;
  int unsigned stall_left   = 0;
  int unsigned idle_cycles  = 0;
  int          beats_sent   = 0;
  int          mismatches   = 0;

  header_attribute_tokenizer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic is_blank(input logic [7:0] b);
    return (b == SpaceChar) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

  function automatic void add_token(input kind_e k, input logic [7:0] v);
    out_beat_t tok;
    if (step_tokens.size() < MaxResults) begin
      tok = '{kind: k, out_byte: v, run_end: 1'b0};
      step_tokens = {step_tokens, tok};
    end
  endfunction

  function automatic void name_step(input logic [7:0] b, input logic fin);
    if (is_blank(b)) begin
      add_token(KIND_AEND, 8'h00);
      tok_mode = MODE_SKIP;
    end else if (b == EqChar && !fin) begin
      tok_mode = MODE_NAMEQ;
    end else begin
      add_token(KIND_NAME, b);
      tok_mode = MODE_NAME;
      if (fin) add_token(KIND_AEND, 8'h00);
    end
  endfunction

  function automatic void value_start(input logic [7:0] b, input logic fin);
    if (b == QuoteChar) begin
      tok_mode = MODE_QUOTE;
      if (fin) add_token(KIND_AEND, 8'h00);
    end else if (b == CommaChar) begin
      add_token(KIND_AEND, 8'h00);
      tok_mode = MODE_SKIP;
    end else begin
      add_token(KIND_VALUE, b);
      tok_mode = MODE_UNQ;
      if (fin) add_token(KIND_AEND, 8'h00);
    end
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b, input logic fin);
    out_beat_t last_tok;
    step_tokens.delete();
    case (tok_mode)
      MODE_NAME: name_step(b, fin);
      MODE_NAMEQ: begin
        if (is_blank(b) || b == EqChar) begin
          add_token(KIND_NAME, EqChar);
          name_step(b, fin);
        end else begin
          value_start(b, fin);
        end
      end
      MODE_QUOTE: begin
        if (b == QuoteChar) begin
          add_token(KIND_AEND, 8'h00);
          tok_mode = MODE_AFTER;
        end else if (b == BslashChar && !fin) begin
          tok_mode = MODE_ESC;
        end else begin
          add_token(KIND_VALUE, b);
          if (fin) add_token(KIND_AEND, 8'h00);
        end
      end
      MODE_ESC: begin
        add_token(KIND_VALUE, b);
        tok_mode = MODE_QUOTE;
        if (fin) add_token(KIND_AEND, 8'h00);
      end
      MODE_UNQ: begin
        if (is_blank(b) || b == CommaChar) begin
          add_token(KIND_AEND, 8'h00);
          tok_mode = MODE_SKIP;
        end else begin
          add_token(KIND_VALUE, b);
          if (fin) add_token(KIND_AEND, 8'h00);
        end
      end
      MODE_AFTER: begin
        if (b == CommaChar || is_blank(b)) tok_mode = MODE_SKIP;
        else name_step(b, fin);
      end
      default: begin
        if (is_blank(b)) tok_mode = MODE_SKIP;
        else name_step(b, fin);
      end
    endcase
    if (fin) begin
      add_token(KIND_EOS, 8'h00);
      tok_mode = MODE_SKIP;
    end
    if (step_tokens.size() != 0) begin
      last_tok = step_tokens.pop_back();
      last_tok.run_end = 1'b1;
      step_tokens = {step_tokens, last_tok};
    end
    expected_tokens = {expected_tokens, step_tokens};
  endfunction

  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected result beat: kind %0d, out_byte 0x%02h", out_beat_o.kind,
               out_beat_o.out_byte);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_beat_o.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_beat_o.kind);
          mismatches++;
        end
        if (out_beat_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, out_beat_o.out_byte);
          mismatches++;
        end
        if (out_beat_o.run_end !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, out_beat_o.run_end);
          mismatches++;
        end
      end
      stall_left = $urandom_range(0, recv_gap_max);
      out_stall_i <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= (stall_left != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= '{data_byte: b, final_byte: fin};
    do @(posedge clk_i); while (in_stall_o);
    tokenize_byte(b, fin);
    beats_sent++;
  endtask

  task automatic send_text(input logic [7:0] txt[$]);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] blank_char();
    int unsigned pick;
    pick = $urandom_range(8, 13);
    return (pick == 8) ? SpaceChar : 8'(pick);
  endfunction

  function automatic logic [7:0] token_char();
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0: return EqChar;
      1: return QuoteChar;
      2: return BslashChar;
      3: return CommaChar;
      4: return blank_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_attr_list();
    logic [7:0] txt[$];
    int unsigned n_attr;
    n_attr = $urandom_range(1, 3);
    for (int a = 0; a < n_attr; a++) begin
      repeat ($urandom_range(0, 1)) txt = {txt, blank_char()};
      repeat ($urandom_range(0, 4)) txt = {txt, token_char()};
      if ($urandom_range(0, 4) != 0) begin
        txt = {txt, EqChar};
        case ($urandom_range(0, 3))
          0: begin
            repeat ($urandom_range(1, 4)) txt = {txt, token_char()};
          end
          1, 2: begin
            txt = {txt, QuoteChar};
            repeat ($urandom_range(0, 4)) begin
              if ($urandom_range(0, 3) == 0) txt = {txt, BslashChar};
              txt = {txt, (($urandom_range(0, 2) == 0) ? noise_char() : token_char())};
            end
            if ($urandom_range(0, 3) != 0) txt = {txt, QuoteChar};
          end
          default: ;
        endcase
      end
      case ($urandom_range(0, 3))
        0: txt = {txt, CommaChar};
        1: begin
          txt = {txt, CommaChar};
          txt = {txt, blank_char()};
        end
        2: txt = {txt, blank_char()};
        default: ;
      endcase
    end
    if (txt.size() == 0) txt = {txt, token_char()};
    send_text(txt);
  endtask

  task automatic test_directed_cases();
    send_text('{8'd9, 8'd10, "k", EqChar, QuoteChar, BslashChar, QuoteChar, QuoteChar,
                CommaChar, 8'hFF, 8'h00});
    send_text('{8'd11, 8'd12, "a", 8'd13, CommaChar, EqChar, SpaceChar});
    send_text('{EqChar, EqChar});
    send_text('{EqChar, CommaChar, EqChar, QuoteChar, BslashChar});
    send_text('{EqChar, QuoteChar});
    wait_idle();
  endtask

  task automatic test_attribute_lists();
    int target;
    target = beats_sent + 260;
    while (beats_sent < target) begin
      send_attr_list();
      if ($urandom_range(0, 9) == 0) wait_idle();
    end
    wait_idle();
  endtask

  task automatic test_back_to_back();
    int target;
    target = beats_sent + 40;
    send_gap_max = 0;
    recv_gap_max = 0;
    while (beats_sent < target) send_attr_list();
    wait_idle();
    send_gap_max = 7;
    recv_gap_max = 7;
  endtask

  task automatic test_byte_noise();
    repeat (59) send_byte(noise_char(), $urandom_range(0, 7) == 0);
    send_byte(noise_char(), 1'b1);
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_attribute_lists();
    test_back_to_back();
    test_byte_noise();
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/hattok_pkg.sv
sv/hattok_decode.sv
sv/hattok_emit.sv
sv/header_attribute_tokenizer_unit.sv
sv/hattok_chk.sv
tb/header_attribute_tokenizer_unit_tb.sv
